[rtl/core/busut_pkg.sv]
// shared types and constants for the bounded unordered set table
`timescale 1ns / 1ps
package busut_pkg;

	localparam int VALUE_W   = 32;
	localparam int OP_W      = 2;
	localparam int ENTRY_W   = 5;
	localparam int CAP_W     = 5;
	localparam int DEPTH_DEF = 16;
	localparam int CAP_RESET = 16;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'd0;

	// what the head cell did with the entry passing it
	typedef struct packed {
		logic match;
		logic place;
		logic drop;
	} head_ctl_t;

endpackage

[rtl/core/bounded_unordered_set_table_unit.sv]
// top level of the bounded unordered set table
`timescale 1ns / 1ps
// Usage:
//   input channel: operation (0 insert, 1 search, 2 remove all copies) and
//   value, one beat per item, valid/stall handshake
//   output channel: ok, found_value and entry_count, exactly one beat per
//   input beat, in order
//   apb port: capacity register at byte address 0, reset 16, write while idle
// Timing:
//   every item makes one full pass of the entry ring plus a finish state
//   between its beat and its result beat; the next beat is taken only once
//   the item has finished, so the block does not take a new item before it
//   is through with the last one
//   the pass length is set by the ring: while a pass runs, entries circulate
//   one cell a cycle through the single compare unit at the head
// Reset:
//   clears the occupancy of every cell, the count and the handshake state;
//   capacity returns to 16
// Stalls:
//   the result waits in the output register while the receiver stalls; the
//   next item may be taken and worked on meanwhile, and it then holds in its
//   finish state until the register frees
module bounded_unordered_set_table_unit
	import busut_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// apb configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OP_W-1:0]          operation,
	input  logic signed [VALUE_W-1:0] value,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok,
	output logic signed [VALUE_W-1:0] found_value,
	output logic [ENTRY_W-1:0]       entry_count
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int STW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   capacity_q;
	logic [CW-1:0]      count_q;
	logic [STW-1:0]     step_q;
	op_t                op_q;
	value_t             key_q;
	logic               flag_q;     // ok so far for the current item
	logic               placed_q;   // insert has found its slot

	logic               out_valid_q;
	logic               ok_q;
	value_t             found_q;
	logic [ENTRY_W-1:0] entry_count_q;

	logic               in_acc;
	logic               out_free;
	logic               shift;
	logic               room;
	logic               last_step;

	// ring wiring: cell i loads from cell i+1, the tail loads from the head
	value_t             cell_data  [DEPTH];
	logic               cell_valid [DEPTH];
	value_t             tail_data;
	logic               tail_valid;
	head_ctl_t          hctl;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	// registers are decoded on the word address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(CAP_RESET);
		end else if (psel && penable && pwrite &&
		             paddr[APB_AW-1:2] == ADDR_CAPACITY[APB_AW-1:2]) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[APB_AW-1:2] == ADDR_CAPACITY[APB_AW-1:2]) ?
	                APB_DW'(capacity_q) : '0;

	// ---------------- handshakes ----------------
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign shift     = (state_q == ST_RUN);
	assign last_step = (step_q == STW'(DEPTH - 1));

	// insert room: below the capacity and below the depth (capacity clips at depth)
	assign room = (CMPW'(count_q) < CMPW'(capacity_q)) && (CMPW'(count_q) < CMPW'(DEPTH));

	// ---------------- the ring ----------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		value_t nd;
		logic   nv;
		if (i == DEPTH - 1) begin : g_tail
			assign nd = tail_data;
			assign nv = tail_valid;
		end else begin : g_mid
			assign nd = cell_data[i+1];
			assign nv = cell_valid[i+1];
		end
		busut_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift),
			.nxt_data  (nd),
			.nxt_valid (nv),
			.data      (cell_data[i]),
			.valid     (cell_valid[i])
		);
	end

	busut_head u_head (
		.op          (op_q),
		.key         (key_q),
		.allow_place (flag_q && !placed_q),
		.head_data   (cell_data[0]),
		.head_valid  (cell_valid[0]),
		.tail_data   (tail_data),
		.tail_valid  (tail_valid),
		.ctl         (hctl)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			step_q   <= '0;
			flag_q   <= 1'b0;
			placed_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q  <= ST_RUN;
						step_q   <= '0;
						placed_q <= 1'b0;
						// insert and remove know their verdict up front
						flag_q   <= (op_t'(operation) == OP_INSERT && room) ||
						            (op_t'(operation) == OP_REMOVE && count_q != '0);
					end
				end
				ST_RUN: begin
					step_q <= step_q + STW'(1);
					if (op_q == OP_SEARCH && hctl.match) begin
						flag_q <= 1'b1;
					end
					if (hctl.place) begin
						placed_q <= 1'b1;
						count_q  <= count_q + CW'(1);
					end else if (hctl.drop) begin
						count_q  <= count_q - CW'(1);
					end
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= op_t'(operation);
			key_q <= value;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			ok_q          <= flag_q;
			found_q       <= (op_q == OP_SEARCH && flag_q) ? key_q : '0;
			entry_count_q <= ENTRY_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign found_value = found_q;
	assign entry_count = entry_count_q;

endmodule

[rtl/core/busut_cell.sv]
// one storage cell of the circulating entry ring
`timescale 1ns / 1ps
module busut_cell
	import busut_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  value_t nxt_data,
	input  logic   nxt_valid,
	output value_t data,
	output logic   valid
);

	value_t data_q;
	logic   valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= nxt_data;
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

[rtl/core/busut_head.sv]
// compare and rewrite logic for the entry leaving the head of the ring
`timescale 1ns / 1ps
module busut_head
	import busut_pkg::*;
(
	input  op_t       op,
	input  value_t    key,
	input  logic      allow_place,
	input  value_t    head_data,
	input  logic      head_valid,
	output value_t    tail_data,
	output logic      tail_valid,
	output head_ctl_t ctl
);

	logic match;

	assign match = head_valid && (head_data == key);

	always_comb begin
		ctl        = '0;
		ctl.match  = match;
		tail_data  = head_data;
		tail_valid = head_valid;
		case (op)
			OP_INSERT: begin
				// first free slot takes the new value
				if (!head_valid && allow_place) begin
					ctl.place  = 1'b1;
					tail_data  = key;
					tail_valid = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (match) begin
					ctl.drop   = 1'b1;
					tail_valid = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
